@@ rtl/mi3_pkg.sv @@
// shared constants for the 3x3 matrix inverse unit
// no dependencies; imported by matrix_inverse_3x3_unit and mi3_checker
`timescale 1ns / 1ps

package mi3_pkg;

    // elements per matrix
    localparam int NUM_ELEM = 9;

    // threshold register width and word index
    localparam int DET_REG_WIDTH = 23;
    localparam logic REG_MIN_DET = 1'b0;

    // cofactor product operands: cofactor k = prod[2k] - prod[2k+1],
    // prod[j] = a[PROD_L[j]] * a[PROD_R[j]], row-major element order
    localparam logic [3:0] PROD_L [18] = '{
        4'd4, 4'd5, 4'd2, 4'd1, 4'd1, 4'd2,
        4'd5, 4'd3, 4'd0, 4'd2, 4'd2, 4'd0,
        4'd3, 4'd4, 4'd1, 4'd0, 4'd0, 4'd1
    };
    localparam logic [3:0] PROD_R [18] = '{
        4'd8, 4'd7, 4'd7, 4'd8, 4'd5, 4'd4,
        4'd6, 4'd8, 4'd8, 4'd6, 4'd3, 4'd5,
        4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3
    };

endpackage

@@ rtl/matrix_inverse_3x3_unit.sv @@
// 3x3 matrix inverse by the adjugate, fully pipelined
// depends on mi3_pkg
`timescale 1ns / 1ps

// Usage
// - s_axis carries one matrix per request: nine signed fixed-point elements
//   packed row-major in tdata, row 1 column 1 in the lowest bits.
// - m_axis returns the inverse in the same format; tuser is the singular
//   flag, and all nine elements are zero when it is set.
// - the APB port holds min_det_magnitude at byte address 0; a determinant
//   whose magnitude is below it (in the input format) marks the matrix
//   singular. Reset value is 1.
// - seven stages of products, cofactors, determinant and threshold check,
//   then one restoring-division stage for the overflow check and one per
//   quotient bit for nine dividers side by side, then the saturation/output
//   register.
// - throughput is one matrix per cycle while m_axis_tready is high.
// - when the receiver stalls with a result waiting, the whole pipeline
//   holds and s_axis_tready drops; nothing is lost or repeated.
// - reset clears all valid bits and sets the threshold register to 1; the
//   block is ready for a request as soon as reset is released.
module matrix_inverse_3x3_unit
    import mi3_pkg::*;
#(
    parameter int ELEMENT_WIDTH = 24,
    parameter int FRAC_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    // in_r1c1, in_r1c2, in_r1c3, in_r2c1 .. in_r3c3, lowest bits first
    input  logic [((NUM_ELEM*ELEMENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // out_r1c1, out_r1c2, out_r1c3, out_r2c1 .. out_r3c3, lowest bits first
    output logic [((NUM_ELEM*ELEMENT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // singular
    output logic m_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);

    localparam int E = ELEMENT_WIDTH;
    localparam int PW = 2*E;
    localparam int CW = 2*E+1;
    localparam int LW = E+1;
    localparam int DW = 3*E+3;
    localparam int NW = CW+2*FRAC_BITS;
    localparam int DVW = DW+E;
    localparam int W = (NW > DVW) ? NW : DVW;
    localparam int CMPW = DW+DET_REG_WIDTH+2*FRAC_BITS;

    typedef struct packed {
        logic [NUM_ELEM-1:0] neg;
        logic [NUM_ELEM-1:0][CW-1:0] mag;
    } cof_t;

    typedef struct packed {
        logic sing;
        logic [DW-1:0] dv;
        logic [NUM_ELEM-1:0] neg;
        logic [NUM_ELEM-1:0] ovf;
        logic [NUM_ELEM-1:0][NW-1:0] rem;
        logic [NUM_ELEM-1:0][E-1:0] q;
    } dstage_t;

    // configuration register
    logic [DET_REG_WIDTH-1:0] mindet_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIN_DET) ? 32'(mindet_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mindet_reg <= DET_REG_WIDTH'(1);
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_MIN_DET)
        begin
            mindet_reg <= pwdata[DET_REG_WIDTH-1:0];
        end
    end

    // pipeline advance: global enable, output register frees the input side
    logic adv;
    logic ovld_reg;
    assign adv = !ovld_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // input unpack
    logic signed [E-1:0] elem [NUM_ELEM];
    always_comb
    begin
        for (int i = 0; i < NUM_ELEM; i++)
        begin
            elem[i] = s_axis_tdata[i*E +: E];
        end
    end

    logic [7:1] v_reg;
    logic signed [PW-1:0] prod1_reg [18];
    logic signed [E-1:0] a1_reg [3];
    logic signed [CW-1:0] cof2_reg [NUM_ELEM];
    logic signed [E-1:0] a2_reg [3];
    logic signed [PW-1:0] dhi3_reg [3];
    logic signed [PW+1:0] dlo3_reg [3];
    cof_t cof3_reg, cof4_reg, cof5_reg, cof6_reg;
    logic signed [DW-1:0] t4_reg [3];
    logic signed [DW-1:0] det5_reg;
    logic [DW-1:0] absdet6_reg;
    logic detneg6_reg;
    logic sing7_reg;
    logic [DW-1:0] absdet7_reg;
    logic [NUM_ELEM-1:0] neg7_reg;
    logic [NUM_ELEM-1:0][CW-1:0] mag7_reg;

    // front stages: products, cofactors, determinant, threshold
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // products
            for (int j = 0; j < 18; j++)
            begin
                prod1_reg[j] <= elem[PROD_L[j]] * elem[PROD_R[j]];
            end
            for (int j = 0; j < 3; j++)
            begin
                a1_reg[j] <= elem[j];
            end
            // cofactors
            for (int k = 0; k < NUM_ELEM; k++)
            begin
                cof2_reg[k] <= CW'(prod1_reg[2*k]) - CW'(prod1_reg[2*k+1]);
            end
            a2_reg <= a1_reg;
            // determinant partial products, split cofactor
            for (int j = 0; j < 3; j++)
            begin
                dhi3_reg[j] <= a2_reg[j] * $signed(cof2_reg[3*j][CW-1:LW]);
                dlo3_reg[j] <= a2_reg[j] * $signed({1'b0, cof2_reg[3*j][LW-1:0]});
            end
            for (int k = 0; k < NUM_ELEM; k++)
            begin
                cof3_reg.neg[k] <= cof2_reg[k][CW-1];
                cof3_reg.mag[k] <= cof2_reg[k][CW-1] ? CW'(-cof2_reg[k]) : CW'(cof2_reg[k]);
            end
            // recombine partial products
            for (int j = 0; j < 3; j++)
            begin
                t4_reg[j] <= (DW'(dhi3_reg[j]) <<< LW) + DW'(dlo3_reg[j]);
            end
            cof4_reg <= cof3_reg;
            // determinant sum
            det5_reg <= t4_reg[0] + t4_reg[1] + t4_reg[2];
            cof5_reg <= cof4_reg;
            // magnitude and sign
            detneg6_reg <= det5_reg[DW-1];
            absdet6_reg <= det5_reg[DW-1] ? DW'(-det5_reg) : DW'(det5_reg);
            cof6_reg <= cof5_reg;
            // singular check, quotient signs
            sing7_reg <= (absdet6_reg == '0)
                || (CMPW'(absdet6_reg) < (CMPW'(mindet_reg) << (2*FRAC_BITS)));
            absdet7_reg <= absdet6_reg;
            neg7_reg <= cof6_reg.neg ^ {NUM_ELEM{detneg6_reg}};
            mag7_reg <= cof6_reg.mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[6:1], s_axis_tvalid};
        end
    end

    // restoring division: stage 0 checks overflow, stage k gives bit E-k
    dstage_t ds_next [E+1];
    dstage_t ds_reg [E+1];
    logic [E:0] dvld_reg;

    genvar gk;
    generate
        for (gk = 0; gk <= E; gk++)
        begin : g_div
            if (gk == 0)
            begin : g_first
                always_comb
                begin
                    ds_next[gk].sing = sing7_reg;
                    ds_next[gk].dv = absdet7_reg;
                    ds_next[gk].neg = neg7_reg;
                    ds_next[gk].q = '0;
                    for (int e = 0; e < NUM_ELEM; e++)
                    begin
                        ds_next[gk].rem[e] = NW'({mag7_reg[e], {(2*FRAC_BITS){1'b0}}});
                        ds_next[gk].ovf[e] = W'(ds_next[gk].rem[e])
                            >= (W'(absdet7_reg) << E);
                    end
                end

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        dvld_reg[gk] <= 1'b0;
                    end
                    else if (adv)
                    begin
                        dvld_reg[gk] <= v_reg[7];
                    end
                end
            end
            else
            begin : g_step
                logic [W-1:0] dsh;
                assign dsh = W'(ds_reg[gk-1].dv) << (E-gk);

                always_comb
                begin
                    ds_next[gk] = ds_reg[gk-1];
                    for (int e = 0; e < NUM_ELEM; e++)
                    begin
                        if (W'(ds_reg[gk-1].rem[e]) >= dsh)
                        begin
                            ds_next[gk].rem[e] = NW'(W'(ds_reg[gk-1].rem[e]) - dsh);
                            ds_next[gk].q[e][E-gk] = 1'b1;
                        end
                    end
                end

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        dvld_reg[gk] <= 1'b0;
                    end
                    else if (adv)
                    begin
                        dvld_reg[gk] <= dvld_reg[gk-1];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    ds_reg[gk] <= ds_next[gk];
                end
            end
        end
    endgenerate

    // saturation and sign, output register
    logic [E-1:0] out_next [NUM_ELEM];
    logic [E-1:0] out_reg [NUM_ELEM];
    logic osing_reg;

    always_comb
    begin
        logic [E-1:0] lim;
        logic [E-1:0] mag;
        for (int e = 0; e < NUM_ELEM; e++)
        begin
            lim = {ds_reg[E].neg[e], {(E-1){~ds_reg[E].neg[e]}}};
            mag = (ds_reg[E].ovf[e] || ds_reg[E].q[e] > lim) ? lim : ds_reg[E].q[e];
            if (ds_reg[E].sing)
            begin
                out_next[e] = '0;
            end
            else if (ds_reg[E].neg[e])
            begin
                out_next[e] = ~mag + E'(1);
            end
            else
            begin
                out_next[e] = mag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
            osing_reg <= ds_reg[E].sing;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
        end
        else if (adv)
        begin
            ovld_reg <= dvld_reg[E];
        end
    end

    // output pack
    always_comb
    begin
        m_axis_tdata = '0;
        for (int e = 0; e < NUM_ELEM; e++)
        begin
            m_axis_tdata[e*E +: E] = out_reg[e];
        end
    end

    assign m_axis_tuser = osing_reg;
    assign m_axis_tvalid = ovld_reg;

endmodule

@@ rtl/mi3_checker.sv @@
// port-level checks for the 3x3 matrix inverse unit, bound to the top level
// depends on mi3_pkg and matrix_inverse_3x3_unit
`timescale 1ns / 1ps

module mi3_checker
    import mi3_pkg::*;
#(
    parameter int ELEMENT_WIDTH = 24
)
(
    input logic clk,
    input logic rst_n,
    input logic s_axis_tready,
    input logic [((NUM_ELEM*ELEMENT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input logic m_axis_tuser,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic pready
);

    // a singular result carries all-zero elements
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("singular result with nonzero elements");

    // a stalled result request holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result request changed while stalled");

    // input is only back-pressured by a waiting result
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with no result waiting");

    // configuration port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind matrix_inverse_3x3_unit mi3_checker #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_mi3_checker (.*);
